[rtl/core/fra_pkg.sv]
// Shared constants for the fraction arithmetic and reduction block.
`default_nettype none
package fra_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int KIND_W            = 2;
  localparam int RES_NUM_W         = 33;
  localparam int RES_DEN_W         = 32;
  localparam int ERR_W             = 1;

  localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SUB = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MUL = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DIV = 2'd3;

endpackage
`default_nettype wire

[rtl/core/fraction_arithmetic_reduce.sv]
// Fraction add/subtract/multiply/divide with reduction by the gcd of the result.
//
// One transaction carries an operation (s_tuser) and two fractions a_num/a_den and
// b_num/b_den. The block cross-multiplies through one shared W x W multiplier,
// forms the numerator and denominator in the following state (S_SUM), then finds
// their gcd with a binary gcd loop and divides both by it with a restoring divider.
// The gcd loop and the divider run on one shared subtractor, one step per cycle,
// and that subtractor sets the latency, which grows with the gcd loop and with
// V = min(2*OPERAND_WIDTH+1, 64) (33 at the default width); the block returns to
// its idle state before the next acceptance. A divide with a zero a_den, b_num
// or b_den skips the loop and returns a zero result with div_error set. Signs are
// not normalized: the denominator may come out negative. The block accepts one
// transaction at a time; a finished result sits in the output register while the
// next transaction is accepted.
`default_nettype none
module fraction_arithmetic_reduce #(
  parameter int OPERAND_WIDTH = fra_pkg::OPERAND_WIDTH_DEF,
  parameter int S_TDATA_W     = ((4 * OPERAND_WIDTH + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // a_num, a_den, b_num, b_den (lowest bits first), zero padded
  input  logic [S_TDATA_W-1:0]        s_tdata,
  // kind
  input  logic [fra_pkg::KIND_W-1:0]  s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // res_num, res_den (lowest bits first), zero padded
  output logic [((fra_pkg::RES_NUM_W + fra_pkg::RES_DEN_W + 7) / 8) * 8 - 1:0] m_tdata,
  // div_error
  output logic [fra_pkg::ERR_W-1:0]   m_tuser
);
  import fra_pkg::*;

  localparam int W         = OPERAND_WIDTH;
  localparam int PW        = 2 * W;
  localparam int VW        = (2 * W + 1 > 64) ? 64 : 2 * W + 1;
  localparam int CW        = $clog2(VW + 1);
  localparam int M_TDATA_W = ((RES_NUM_W + RES_DEN_W + 7) / 8) * 8;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_GCD  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]          state;
  logic [1:0]          mcnt;
  logic [KIND_W-1:0]   kind;
  logic signed [W-1:0] a_num, a_den, b_num, b_den;
  logic signed [PW-1:0] pa, pb, pd;
  logic                num_neg, den_neg, div_err, div_den;
  logic [VW-1:0]       mag_den, x, y, g, dq, rem, qn, qd;
  logic [CW-1:0]       k, cnt;

  // Multiplier operand select
  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] mul_p;

  always_comb begin
    unique case (mcnt)
      2'd0: begin
        mul_a = a_num;
        mul_b = (kind == KIND_MUL) ? b_num : b_den;
      end
      2'd1: begin
        mul_a = b_num;
        mul_b = a_den;
      end
      default: begin
        mul_a = a_den;
        mul_b = (kind == KIND_DIV) ? b_num : b_den;
      end
    endcase
  end

  assign mul_p = PW'(mul_a * mul_b);

  // Combine products into numerator and denominator
  logic [VW-1:0] num_v, den_v, num_mag, den_mag;
  logic          zero_op;

  always_comb begin
    unique case (kind)
      KIND_ADD: num_v = VW'(pa) + VW'(pb);
      KIND_SUB: num_v = VW'(pa) - VW'(pb);
      KIND_MUL: num_v = VW'(pa);
      KIND_DIV: num_v = VW'(pa);
      default:  num_v = VW'(pa);
    endcase
  end

  assign den_v   = VW'(pd);
  assign num_mag = num_v[VW-1] ? (~num_v + 1'b1) : num_v;
  assign den_mag = den_v[VW-1] ? (~den_v + 1'b1) : den_v;
  assign zero_op = (a_den == '0) || (b_num == '0) || (b_den == '0);

  // Shared subtractor: gcd compare/subtract and divider trial subtract
  logic [VW:0]   sub_a, sub_b;
  logic [VW+1:0] sub_d;
  logic          borrow;

  always_comb begin
    if (state == S_DIV) begin
      sub_a = {rem, dq[VW-1]};
      sub_b = {1'b0, g};
    end else begin
      sub_a = {1'b0, x};
      sub_b = {1'b0, y};
    end
  end

  assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow = sub_d[VW+1];

  logic [VW-1:0] dq_next;
  assign dq_next = {dq[VW-2:0], ~borrow};

  // Signed result and output packing
  logic [VW-1:0]    sn, sd;
  logic signed [63:0] sn64, sd64;

  assign sn   = num_neg ? (~qn + 1'b1) : qn;
  assign sd   = den_neg ? (~qd + 1'b1) : qd;
  assign sn64 = 64'(signed'(sn));
  assign sd64 = 64'(signed'(sd));

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      mcnt     <= 2'd0;
    end else begin
      // Drop the output once taken, unless a new result loads it this cycle
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            kind  <= s_tuser;
            a_num <= s_tdata[W-1:0];
            a_den <= s_tdata[2*W-1:W];
            b_num <= s_tdata[3*W-1:2*W];
            b_den <= s_tdata[4*W-1:3*W];
            mcnt  <= 2'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          unique case (mcnt)
            2'd0:    pa <= mul_p;
            2'd1:    pb <= mul_p;
            default: pd <= mul_p;
          endcase
          mcnt <= mcnt + 2'd1;
          if (mcnt == 2'd2) begin
            mcnt  <= 2'd0;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          num_neg <= num_v[VW-1];
          den_neg <= den_v[VW-1];
          mag_den <= den_mag;
          x       <= num_mag;
          y       <= den_mag;
          dq      <= num_mag;
          k       <= '0;
          if (kind == KIND_DIV && zero_op) begin
            div_err <= 1'b1;
            qn      <= '0;
            qd      <= '0;
            state   <= S_DONE;
          end else begin
            div_err <= 1'b0;
            state   <= S_GCD;
          end
        end
        S_GCD: begin
          if (x == '0 || y == '0) begin
            // Both zero: return 0/0 without dividing
            if (x == '0 && y == '0) begin
              qn    <= '0;
              qd    <= '0;
              state <= S_DONE;
            end else begin
              g       <= ((x == '0) ? y : x) << k;
              rem     <= '0;
              cnt     <= '0;
              div_den <= 1'b0;
              state   <= S_DIV;
            end
          end else if (!x[0] && !y[0]) begin
            x <= x >> 1;
            y <= y >> 1;
            k <= k + 1'b1;
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (borrow) begin
            // Swap so the larger value sits in x
            x <= y;
            y <= x;
          end else begin
            x <= sub_d[VW-1:0];
          end
        end
        S_DIV: begin
          rem <= borrow ? sub_a[VW-1:0] : sub_d[VW-1:0];
          dq  <= dq_next;
          cnt <= cnt + 1'b1;
          if (cnt == CW'(VW - 1)) begin
            cnt <= '0;
            rem <= '0;
            if (!div_den) begin
              qn      <= dq_next;
              dq      <= mag_den;
              div_den <= 1'b1;
            end else begin
              qd    <= dq_next;
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          // Hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= M_TDATA_W'({sd64[RES_DEN_W-1:0], sn64[RES_NUM_W-1:0]});
            m_tuser  <= ERR_W'(div_err);
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("block still ready after accepting a transaction");

  a_err_zero_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("divide error with nonzero result");

  a_gcd_shift_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_GCD |-> k < CW'(VW))
    else $error("gcd common shift count out of range");

  a_div_count_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> cnt < CW'(VW) && g != '0)
    else $error("divider step count or divisor out of range");
`endif

endmodule
`default_nettype wire
